// ===== src/rlsm_pkg.sv =====
// rlsm_pkg: shared types and constants for the redundant load safety monitor.
// Holds the mode/cause encodings, config register indexes and the config struct.
// No dependencies.
`default_nettype none

package rlsm_pkg;

    localparam int unsigned PERMILLE = 1000;
    // floor for the mismatch denominator: 1 kg in 1/16 kg units
    localparam int unsigned ONE_KG   = 16;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_FAILSAFE = 2'd1,
        MODE_DESCENT  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_OK        = 3'd0,
        CAUSE_HEARTBEAT = 3'd1,
        CAUSE_MISMATCH  = 3'd2,
        CAUSE_OVERLOAD  = 3'd3,
        CAUSE_DROP      = 3'd4
    } cause_t;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HB_TIMEOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_LIMIT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISMATCH   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_RATE  = 8'd3;

    localparam logic [15:0] RST_HB_TIMEOUT = 16'd1000;
    localparam logic [14:0] RST_LOAD_LIMIT = 15'd800;
    localparam logic [9:0]  RST_MISMATCH   = 10'd200;
    localparam logic [15:0] RST_DROP_RATE  = 16'd160;

    typedef struct packed {
        logic [15:0] hb_timeout_ms;
        logic [14:0] load_limit;
        logic [9:0]  mismatch_permille;
        logic [15:0] drop_rate_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/rlsm_cfg_regs.sv =====
// rlsm_cfg_regs: configuration register file of the load safety monitor.
// Depends on rlsm_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module rlsm_cfg_regs
    import rlsm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HB_TIMEOUT: cfg_next.hb_timeout_ms     = cfg_data;
                CFG_LOAD_LIMIT: cfg_next.load_limit        = cfg_data[14:0];
                CFG_MISMATCH:   cfg_next.mismatch_permille = cfg_data[9:0];
                CFG_DROP_RATE:  cfg_next.drop_rate_limit   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hb_timeout_ms     <= RST_HB_TIMEOUT;
            cfg_reg.load_limit        <= RST_LOAD_LIMIT;
            cfg_reg.mismatch_permille <= RST_MISMATCH;
            cfg_reg.drop_rate_limit   <= RST_DROP_RATE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rlsm_check.sv =====
// rlsm_check: combinational safety checks for one sample, in priority order.
// Depends on rlsm_pkg (cfg_t, mode_t, cause_t, PERMILLE, ONE_KG).
`default_nettype none

module rlsm_check
    import rlsm_pkg::*;
#(
    parameter int LOAD_WIDTH = 16
) (
    input  wire cfg_t                           cfg,
    input  wire logic signed [LOAD_WIDTH-1:0]   primary_left,
    input  wire logic signed [LOAD_WIDTH-1:0]   primary_right,
    input  wire logic signed [LOAD_WIDTH-1:0]   secondary_left,
    input  wire logic signed [LOAD_WIDTH-1:0]   secondary_right,
    input  wire logic [31:0]                    now_ms,
    input  wire logic [31:0]                    last_hb_ms,
    input  wire logic signed [LOAD_WIDTH-1:0]   prev_left,
    input  wire logic signed [LOAD_WIDTH-1:0]   prev_right,
    input  wire logic [31:0]                    prev_stamp_ms,
    output mode_t                               mode,
    output cause_t                              cause
);

    localparam int MUL_W  = LOAD_WIDTH + 11;
    localparam int DROP_W = (MUL_W > 48) ? MUL_W : 48;
    localparam int OVL_W  = ((LOAD_WIDTH > 15) ? LOAD_WIDTH : 15) + 1;
    localparam logic signed [LOAD_WIDTH-1:0] KG_MIN = LOAD_WIDTH'(ONE_KG);

    // |a - b| * 1000 > permille * max(a, b, 1 kg)
    function automatic logic side_mismatch(
        input logic signed [LOAD_WIDTH-1:0] a,
        input logic signed [LOAD_WIDTH-1:0] b,
        input logic [9:0]                   pm
    );
        logic signed [LOAD_WIDTH-1:0] d;
        logic signed [LOAD_WIDTH:0]   delta;
        logic [LOAD_WIDTH:0]          mag;
        logic [MUL_W-1:0]             lhs;
        logic [MUL_W-1:0]             rhs;
        d = (a > b) ? a : b;
        if (d < KG_MIN) begin
            d = KG_MIN;
        end
        delta = {a[LOAD_WIDTH-1], a} - {b[LOAD_WIDTH-1], b};
        mag   = delta[LOAD_WIDTH] ? unsigned'(-delta) : unsigned'(delta);
        lhs   = MUL_W'(mag) * MUL_W'(PERMILLE);
        rhs   = MUL_W'(pm) * MUL_W'(unsigned'(d));
        return lhs > rhs;
    endfunction

    // (prev - cur) * 1000 > rate * dt; a rise never fires
    function automatic logic side_drop(
        input logic signed [LOAD_WIDTH-1:0] prev,
        input logic signed [LOAD_WIDTH-1:0] cur,
        input logic [15:0]                  rate,
        input logic [31:0]                  dt
    );
        logic signed [LOAD_WIDTH:0] delta;
        logic [DROP_W-1:0]          lhs;
        logic [DROP_W-1:0]          rhs;
        delta = {prev[LOAD_WIDTH-1], prev} - {cur[LOAD_WIDTH-1], cur};
        lhs   = DROP_W'(delta[LOAD_WIDTH-1:0]) * DROP_W'(PERMILLE);
        rhs   = DROP_W'(rate) * DROP_W'(dt);
        return !delta[LOAD_WIDTH] && (lhs > rhs);
    endfunction

    logic [31:0]             hb_age;
    logic [31:0]             dt;
    logic                    hb_timeout;
    logic                    mismatch;
    logic                    overload;
    logic                    drop;
    logic signed [OVL_W-1:0] limit_x;

    assign hb_age     = now_ms - last_hb_ms;
    assign dt         = now_ms - prev_stamp_ms;
    assign hb_timeout = hb_age > {16'd0, cfg.hb_timeout_ms};
    assign mismatch   = side_mismatch(primary_left, secondary_left, cfg.mismatch_permille)
                     || side_mismatch(primary_right, secondary_right, cfg.mismatch_permille);
    assign limit_x    = signed'(OVL_W'(cfg.load_limit));
    assign overload   = (OVL_W'(primary_left) > limit_x) || (OVL_W'(primary_right) > limit_x);
    assign drop       = (dt != 32'd0)
                     && (side_drop(prev_left, primary_left, cfg.drop_rate_limit, dt)
                      || side_drop(prev_right, primary_right, cfg.drop_rate_limit, dt));

    always_comb begin
        if (hb_timeout) begin
            cause = CAUSE_HEARTBEAT;
            mode  = MODE_FAILSAFE;
        end else if (mismatch) begin
            cause = CAUSE_MISMATCH;
            mode  = MODE_FAILSAFE;
        end else if (overload) begin
            cause = CAUSE_OVERLOAD;
            mode  = MODE_FAILSAFE;
        end else if (drop) begin
            cause = CAUSE_DROP;
            mode  = MODE_DESCENT;
        end else begin
            cause = CAUSE_OK;
            mode  = MODE_NORMAL;
        end
    end

endmodule

`default_nettype wire

// ===== src/redundant_load_safety_monitor.sv =====
// Channel   Dir  Handshake              Payload
// s_*       in   s_valid / s_ready      four loads, heartbeat flag + stamp, now_ms
// m_*       out  m_valid / m_ready      mode, cause, release/descent latches
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Input beat to result: input register, then the checks and the state
// update land in the result register. One beat per cycle sustained while
// m_ready is high; the checks are a single combinational pass.
// aresetn (sync, low) clears both stages, the config to defaults and all state.
// A stalled m_ready holds the result; the input register still takes one beat.
// Depends on rlsm_pkg, rlsm_cfg_regs, rlsm_check.
`default_nettype none

module redundant_load_safety_monitor
    import rlsm_pkg::*;
#(
    parameter int LOAD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [LOAD_WIDTH-1:0]  s_primary_left_load,
    input  wire logic signed [LOAD_WIDTH-1:0]  s_primary_right_load,
    input  wire logic signed [LOAD_WIDTH-1:0]  s_secondary_left_load,
    input  wire logic signed [LOAD_WIDTH-1:0]  s_secondary_right_load,
    input  wire logic                          s_heartbeat_valid,
    input  wire logic [31:0]                   s_heartbeat_stamp_ms,
    input  wire logic [31:0]                   s_now_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_mode,
    output logic [2:0]                         m_cause,
    output logic                               m_release_active,
    output logic                               m_descent_active
);

    cfg_t cfg;

    rlsm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [LOAD_WIDTH-1:0]  pl_reg;
    logic signed [LOAD_WIDTH-1:0]  pr_reg;
    logic signed [LOAD_WIDTH-1:0]  sl_reg;
    logic signed [LOAD_WIDTH-1:0]  sr_reg;
    logic                          hb_valid_reg;
    logic [31:0]                   hb_stamp_reg;
    logic [31:0]                   now_reg;

    // result stage
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mode_t                         mode_reg;
    cause_t                        cause_reg;

    // monitor state
    logic [31:0]                   last_hb_reg;
    logic [31:0]                   last_hb_next;
    logic signed [LOAD_WIDTH-1:0]  prev_left_reg;
    logic signed [LOAD_WIDTH-1:0]  prev_left_next;
    logic signed [LOAD_WIDTH-1:0]  prev_right_reg;
    logic signed [LOAD_WIDTH-1:0]  prev_right_next;
    logic [31:0]                   prev_stamp_reg;
    logic [31:0]                   prev_stamp_next;
    logic                          release_reg;
    logic                          release_next;
    logic                          descent_reg;
    logic                          descent_next;

    logic                          advance;
    logic                          fire;
    logic                          load_in;
    logic [31:0]                   hb_eff;
    mode_t                         chk_mode;
    cause_t                        chk_cause;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = advance && in_valid_reg;
    assign s_ready = !in_valid_reg || advance;
    assign load_in = s_valid && s_ready;

    // a fresh heartbeat stamp counts for this same sample
    assign hb_eff = hb_valid_reg ? hb_stamp_reg : last_hb_reg;

    rlsm_check #(
        .LOAD_WIDTH (LOAD_WIDTH)
    ) u_check (
        .cfg             (cfg),
        .primary_left    (pl_reg),
        .primary_right   (pr_reg),
        .secondary_left  (sl_reg),
        .secondary_right (sr_reg),
        .now_ms          (now_reg),
        .last_hb_ms      (hb_eff),
        .prev_left       (prev_left_reg),
        .prev_right      (prev_right_reg),
        .prev_stamp_ms   (prev_stamp_reg),
        .mode            (chk_mode),
        .cause           (chk_cause)
    );

    always_comb begin
        in_valid_next   = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next  = advance ? in_valid_reg : out_valid_reg;
        last_hb_next    = last_hb_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        prev_stamp_next = prev_stamp_reg;
        release_next    = release_reg;
        descent_next    = descent_reg;
        if (fire) begin
            last_hb_next = hb_eff;
            if (chk_cause == CAUSE_OK) begin
                prev_left_next  = pl_reg;
                prev_right_next = pr_reg;
                prev_stamp_next = now_reg;
            end else begin
                release_next = 1'b1;
                if (chk_cause == CAUSE_DROP) begin
                    descent_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_hb_reg    <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_stamp_reg <= '0;
            release_reg    <= 1'b0;
            descent_reg    <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            last_hb_reg    <= last_hb_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            prev_stamp_reg <= prev_stamp_next;
            release_reg    <= release_next;
            descent_reg    <= descent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            pl_reg       <= s_primary_left_load;
            pr_reg       <= s_primary_right_load;
            sl_reg       <= s_secondary_left_load;
            sr_reg       <= s_secondary_right_load;
            hb_valid_reg <= s_heartbeat_valid;
            hb_stamp_reg <= s_heartbeat_stamp_ms;
            now_reg      <= s_now_ms;
        end
        if (fire) begin
            mode_reg  <= chk_mode;
            cause_reg <= chk_cause;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mode           = mode_reg;
    assign m_cause          = cause_reg;
    assign m_release_active = release_reg;
    assign m_descent_active = descent_reg;

    // descent is only ever entered together with release
    a_descent_implies_release: assert property (@(posedge aclk) disable iff (!aresetn)
        descent_reg |-> release_reg)
        else $error("descent latch set without release latch");

    a_release_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        release_reg |=> release_reg)
        else $error("release latch cleared outside reset");

    a_fault_shown_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && cause_reg != CAUSE_OK) |-> release_reg)
        else $error("fault result shown with release latch clear");

    a_prev_moves_on_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(prev_stamp_reg) |-> (out_valid_reg && cause_reg == CAUSE_OK))
        else $error("previous frame updated by a failing sample");

endmodule

`default_nettype wire
